### src/ipa_pkg.sv
`timescale 1ns / 1ps

package ipa_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int TIME_BITS = 20;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int CHILD_W   = IDX_W + 2;
    localparam int SLOT_W    = 9;
    localparam int S_DATA_W  = ((2 * TIME_BITS + 7) / 8) * 8;
    localparam int M_DATA_W  = ((2 * SLOT_W + 7) / 8) * 8;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [CNT_W-1:0]     count_t;
    typedef logic [IDX_W-1:0]     index_t;

    typedef struct packed {
        time_t  end_time;
        count_t slot;
    } heap_entry_t;

    typedef struct packed {
        logic load;
        logic rd_root;
        logic open_slot;
        logic reuse_slot;
        logic set_ovf;
        logic rd_up;
        logic move_up;
        logic rd_dn;
        logic move_dn;
        logic put;
        logic emit;
    } ipa_cmd_t;

    typedef struct packed {
        logic new_slot;
        logic full;
        logic at_root;
        logic up_move;
        logic dn_leaf;
        logic dn_move;
        logic out_free;
    } ipa_status_t;

    // Heap order: earlier end first, lower slot number on a tie.
    function automatic logic key_less(heap_entry_t a, heap_entry_t b);
        logic r;
        if (a.end_time != b.end_time) begin
            r = (a.end_time < b.end_time);
        end else begin
            r = (a.slot < b.slot);
        end
        return r;
    endfunction

endpackage

### src/ipa_datapath.sv
`timescale 1ns / 1ps

module ipa_datapath
    import ipa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ipa_cmd_t            cmd,
    output ipa_status_t         status,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [0:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [0:0]          m_tuser
);

    heap_entry_t heap_mem [MAX_SLOTS];
    heap_entry_t rd_a_reg;
    heap_entry_t rd_b_reg;

    count_t      count_reg,  count_next;
    time_t       start_reg;
    heap_entry_t key_reg;
    index_t      pos_reg;
    count_t      res_slot_reg;
    logic        res_ovf_reg;
    logic        m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;
    logic        m_user_reg;

    index_t               parent;
    logic [CHILD_W-1:0]   left_idx;
    logic [CHILD_W-1:0]   right_idx;
    logic                 left_ok;
    logic                 right_ok;
    heap_entry_t          best_entry;
    index_t               best_idx;
    logic                 best_moved;
    index_t               rd_a_addr;
    heap_entry_t          wr_data;
    count_t               count_inc;

    assign count_inc = count_reg + 1'b1;
    assign parent    = (pos_reg - 1'b1) >> 1;
    assign left_idx  = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + 1'b1;
    assign left_ok   = left_idx  < CHILD_W'(count_reg);
    assign right_ok  = right_idx < CHILD_W'(count_reg);

    // Pick the smallest of the held key and the two children.
    always_comb begin
        best_entry = key_reg;
        best_idx   = pos_reg;
        best_moved = 1'b0;
        if (left_ok && key_less(rd_a_reg, best_entry)) begin
            best_entry = rd_a_reg;
            best_idx   = left_idx[IDX_W-1:0];
            best_moved = 1'b1;
        end
        if (right_ok && key_less(rd_b_reg, best_entry)) begin
            best_entry = rd_b_reg;
            best_idx   = right_idx[IDX_W-1:0];
            best_moved = 1'b1;
        end
    end

    always_comb begin
        if (cmd.rd_root) begin
            rd_a_addr = '0;
        end else if (cmd.rd_up) begin
            rd_a_addr = parent;
        end else begin
            rd_a_addr = left_idx[IDX_W-1:0];
        end
    end

    always_comb begin
        if (cmd.put) begin
            wr_data = key_reg;
        end else if (cmd.move_up) begin
            wr_data = rd_a_reg;
        end else begin
            wr_data = best_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_root || cmd.rd_up || cmd.rd_dn) begin
            rd_a_reg <= heap_mem[rd_a_addr];
        end
        if (cmd.rd_dn) begin
            rd_b_reg <= heap_mem[right_idx[IDX_W-1:0]];
        end
        if (cmd.put || cmd.move_up || cmd.move_dn) begin
            heap_mem[pos_reg] <= wr_data;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.load && s_tuser[0]) begin
            count_next = '0;
        end else if (cmd.open_slot) begin
            count_next = count_inc;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            start_reg        <= s_tdata[TIME_BITS-1:0];
            key_reg.end_time <= s_tdata[2*TIME_BITS-1:TIME_BITS];
        end
        if (cmd.open_slot) begin
            key_reg.slot <= count_inc;
            pos_reg      <= index_t'(count_reg);
            res_slot_reg <= count_inc;
            res_ovf_reg  <= 1'b0;
        end
        if (cmd.reuse_slot) begin
            key_reg.slot <= rd_a_reg.slot;
            pos_reg      <= '0;
            res_slot_reg <= rd_a_reg.slot;
            res_ovf_reg  <= 1'b0;
        end
        if (cmd.set_ovf) begin
            res_slot_reg <= '0;
            res_ovf_reg  <= 1'b1;
        end
        if (cmd.move_up) begin
            pos_reg <= parent;
        end
        if (cmd.move_dn) begin
            pos_reg <= best_idx;
        end
        if (cmd.emit) begin
            m_data_reg <= M_DATA_W'({SLOT_W'(count_reg), SLOT_W'(res_slot_reg)});
            m_user_reg <= res_ovf_reg;
        end
    end

    assign status.new_slot = (count_reg == '0) || (rd_a_reg.end_time >= start_reg);
    assign status.full     = (count_reg == CNT_W'(MAX_SLOTS));
    assign status.at_root  = (pos_reg == '0);
    assign status.up_move  = key_less(key_reg, rd_a_reg);
    assign status.dn_leaf  = !left_ok;
    assign status.dn_move  = best_moved;
    assign status.out_free = !m_valid_reg || m_tready;

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule

### src/ipa_ctrl.sv
`timescale 1ns / 1ps

module ipa_ctrl
    import ipa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  ipa_status_t status,
    output ipa_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ROOT_RD = 3'd1;
    localparam logic [2:0] ST_DECIDE  = 3'd2;
    localparam logic [2:0] ST_UP_RD   = 3'd3;
    localparam logic [2:0] ST_UP_CMP  = 3'd4;
    localparam logic [2:0] ST_DN_RD   = 3'd5;
    localparam logic [2:0] ST_DN_CMP  = 3'd6;
    localparam logic [2:0] ST_FINISH  = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_ROOT_RD;
                end
            end
            ST_ROOT_RD: begin
                cmd.rd_root = 1'b1;
                state_next  = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (status.new_slot && status.full) begin
                    cmd.set_ovf = 1'b1;
                    state_next  = ST_FINISH;
                end else if (status.new_slot) begin
                    cmd.open_slot = 1'b1;
                    state_next    = ST_UP_RD;
                end else begin
                    cmd.reuse_slot = 1'b1;
                    state_next     = ST_DN_RD;
                end
            end
            ST_UP_RD: begin
                if (status.at_root) begin
                    cmd.put    = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    cmd.rd_up  = 1'b1;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                if (status.up_move) begin
                    cmd.move_up = 1'b1;
                    state_next  = ST_UP_RD;
                end else begin
                    cmd.put    = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_DN_RD: begin
                if (status.dn_leaf) begin
                    cmd.put    = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    cmd.rd_dn  = 1'b1;
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_CMP: begin
                if (status.dn_move) begin
                    cmd.move_dn = 1'b1;
                    state_next  = ST_DN_RD;
                end else begin
                    cmd.put    = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

### src/interval_partition_allocator.sv
`timescale 1ns / 1ps
// Each word takes a root read and an open/reuse/overflow decision; on overflow the sift
// is skipped, else a heap sift walks the heap level by level, with one memory read step
// and one compare/write step per level. A new input word is taken only once the previous
// word's result has been loaded into the output register.
// A stalled result holds the controller until the output register frees up.
// Reset (aresetn low, synchronous): heap empty, no result pending, FSM idle.

module interval_partition_allocator
    import ipa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Input word.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [19:0] start_time, [39:20] end_time
    input  logic [0:0]          s_tuser,   // [0] new_batch
    // Result word.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [8:0] slot_number, [17:9] slots_used
    output logic [0:0]          m_tuser    // [0] overflow
);

    // The controller sequences one word at a time: root read, the
    // open/reuse/overflow decision, then, except on overflow, a sift up (new
    // slot) or a sift down (reused slot) over the heap memory, and finally a
    // load of the output register. The output register frees the input side,
    // so the next word can be taken while a result still waits downstream.
    ipa_cmd_t    cmd;
    ipa_status_t status;

    ipa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: heap memory (two read ports, one write port), slot count,
    // held key and hole position, result and output registers.
    ipa_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### src/ipa_checker.sv
`timescale 1ns / 1ps

module ipa_checker
    import ipa_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic [0:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [0:0]          m_tuser
);

    // Overflow reports no slot and a full count.
    a_ovf_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
        (m_tdata[SLOT_W-1:0] == '0) && (m_tdata[2*SLOT_W-1:SLOT_W] == SLOT_W'(MAX_SLOTS)))
        else $error("overflow word carries a slot or a short count");

    // A granted slot is numbered from 1 and never beyond the open count.
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |->
        (m_tdata[SLOT_W-1:0] != '0) &&
        (m_tdata[SLOT_W-1:0] <= m_tdata[2*SLOT_W-1:SLOT_W]))
        else $error("slot number outside 1..slots_used");

    // One word in flight: the input closes right after it takes a word.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted two words back to back");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind interval_partition_allocator ipa_checker u_ipa_checker (.*);
